// ----- src/tis_pkg.sv -----
package tis_pkg;

  localparam logic [7:0] T_IAC  = 8'hFF;
  localparam logic [7:0] T_DONT = 8'hFE;
  localparam logic [7:0] T_DO   = 8'hFD;
  localparam logic [7:0] T_WONT = 8'hFC;
  localparam logic [7:0] T_WILL = 8'hFB;
  localparam logic [7:0] T_SB   = 8'hFA;
  localparam logic [7:0] T_SE   = 8'hF0;
  localparam logic [7:0] T_NAWS = 8'h1F;

  localparam int unsigned NAWS_LEN   = 12;
  localparam int unsigned NAWS_IDX_W = $clog2(NAWS_LEN);
  localparam logic [NAWS_IDX_W-1:0] NAWS_LAST = NAWS_IDX_W'(NAWS_LEN - 1);

  localparam logic        REG_COLUMNS   = 1'b0;
  localparam logic        REG_ROWS      = 1'b1;
  localparam logic [15:0] COLUMNS_RESET = 16'd80;
  localparam logic [15:0] ROWS_RESET    = 16'd24;

  typedef enum logic [4:0] {
    PH_NORMAL = 5'b00001,
    PH_IAC    = 5'b00010,
    PH_OPT    = 5'b00100,
    PH_SUB    = 5'b01000,
    PH_SUBIAC = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic       naws;
    logic [7:0] data;
  } emit_t;

  function automatic logic [7:0] naws_byte(input logic [NAWS_IDX_W-1:0] idx,
                                           input logic [15:0] cols,
                                           input logic [15:0] rows);
    logic [7:0] b;
    case (idx)
      4'd0:    b = T_IAC;
      4'd1:    b = T_WILL;
      4'd2:    b = T_NAWS;
      4'd3:    b = T_IAC;
      4'd4:    b = T_SB;
      4'd5:    b = T_NAWS;
      4'd6:    b = cols[15:8];
      4'd7:    b = cols[7:0];
      4'd8:    b = rows[15:8];
      4'd9:    b = rows[7:0];
      4'd10:   b = T_IAC;
      4'd11:   b = T_SE;
      default: b = T_SE;
    endcase
    return b;
  endfunction

endpackage

// ----- src/tis_parser.sv -----
module tis_parser
  import tis_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] server_byte,
  output emit_t      emit
);

  phase_t     phase, phase_next;
  logic [7:0] verb, verb_next;

  always_comb begin
    phase_next = phase;
    verb_next  = verb;
    emit       = '{valid: 1'b0, naws: 1'b0, data: server_byte};
    case (phase)
      PH_IAC: begin
        if (server_byte == T_IAC) begin
          emit.valid = 1'b1;
          phase_next = PH_NORMAL;
        end else if (server_byte == T_SB) begin
          phase_next = PH_SUB;
        end else if (server_byte == T_WILL || server_byte == T_WONT ||
                     server_byte == T_DO || server_byte == T_DONT) begin
          verb_next  = server_byte;
          phase_next = PH_OPT;
        end else begin
          phase_next = PH_NORMAL;
        end
      end
      PH_OPT: begin
        if (verb == T_DO && server_byte == T_NAWS) begin
          emit.valid = 1'b1;
          emit.naws  = 1'b1;
        end
        phase_next = PH_NORMAL;
      end
      PH_SUB: begin
        if (server_byte == T_IAC) begin
          phase_next = PH_SUBIAC;
        end
      end
      PH_SUBIAC: begin
        phase_next = (server_byte == T_SE) ? PH_NORMAL : PH_SUB;
      end
      default: begin
        if (server_byte == T_IAC) begin
          phase_next = PH_IAC;
        end else begin
          emit.valid = 1'b1;
          phase_next = PH_NORMAL;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NORMAL;
      verb  <= 8'd0;
    end else if (accept) begin
      phase <= phase_next;
      verb  <= verb_next;
    end
  end

endmodule

// ----- src/telnet_iac_stripper_core.sv -----
// Telnet command stripper: takes one server byte per transfer and passes plain
// data to the terminal (to_server = 0), folding IAC IAC into one 0xFF and
// dropping commands, option negotiation and subnegotiation. A DO NAWS request
// produces the 12-byte window-size reply toward the server (to_server = 1)
// built from window_columns (register 0) and window_rows (register 1).
// With out_ready held high one byte is taken every cycle; a byte is parsed in
// the cycle it is accepted and its result sits in the output register the next
// cycle. A window-size reply holds the input off while the output register
// steps through the reply. last_of_run marks the final result of each input
// byte.
module telnet_iac_stripper_core
  import tis_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  server_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        to_server,
  output logic [7:0]  out_byte,
  output logic        last_of_run
);

  logic [15:0]           window_columns;
  logic [15:0]           window_rows;
  logic                  out_naws;
  logic [7:0]            out_data;
  logic [NAWS_IDX_W-1:0] naws_idx;
  logic                  accept;
  emit_t                 emit;

  tis_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .server_byte (server_byte),
    .emit        (emit)
  );

  assign last_of_run = !out_naws || (naws_idx == NAWS_LAST);
  assign in_ready    = !out_valid || (out_ready && last_of_run);
  assign accept      = in_valid && in_ready;
  assign to_server   = out_naws;
  assign out_byte    = out_naws ? naws_byte(naws_idx, window_columns, window_rows) : out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_columns <= COLUMNS_RESET;
      window_rows    <= ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMNS: window_columns <= cfg_data;
        REG_ROWS:    window_rows    <= cfg_data;
        default:     window_rows    <= window_rows;
      endcase
    end
  end

  // output register and reply sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_naws  <= 1'b0;
      naws_idx  <= '0;
    end else if (accept) begin
      out_valid <= emit.valid;
      out_naws  <= emit.naws;
      naws_idx  <= '0;
    end else if (out_valid && out_ready) begin
      if (last_of_run) begin
        out_valid <= 1'b0;
      end else begin
        naws_idx <= naws_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= emit.data;
    end
  end

endmodule

// ----- sim/telnet_iac_stripper_core_tb.sv -----
module telnet_iac_stripper_core_tb;
  import tis_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic       to_server;
    logic [7:0] value;
    logic       last;
  } emitted_t;

  class stripped_stream_board;
    logic [15:0] columns;
    logic [15:0] rows;
    phase_t      phase;
    logic [7:0]  verb;
    emitted_t    due_bytes[$];
    int          errors;

    function new();
      columns = COLUMNS_RESET;
      rows    = ROWS_RESET;
      phase   = PH_NORMAL;
      verb    = 8'h00;
      errors  = 0;
    endfunction

    function void set_window(logic idx, logic [15:0] value);
      if (idx == REG_COLUMNS) begin
        columns = value;
      end else begin
        rows = value;
      end
    endfunction

    function void add_due(logic dir, logic [7:0] value, logic last);
      emitted_t e;
      e.to_server = dir;
      e.value     = value;
      e.last      = last;
      due_bytes.push_back(e);
    endfunction

    function void add_window_reply();
      logic [7:0] seq [12];
      seq = '{T_IAC, T_WILL, T_NAWS, T_IAC, T_SB, T_NAWS,
              columns[15:8], columns[7:0], rows[15:8], rows[7:0], T_IAC, T_SE};
      for (int i = 0; i < 12; i++) begin
        add_due(1'b1, seq[i], i == 11);
      end
    endfunction

    function void take_server_byte(logic [7:0] b);
      case (phase)
        PH_IAC: begin
          if (b == T_IAC) begin
            add_due(1'b0, T_IAC, 1'b1);
            phase = PH_NORMAL;
          end else if (b == T_SB) begin
            phase = PH_SUB;
          end else if (b == T_WILL || b == T_WONT || b == T_DO || b == T_DONT) begin
            verb  = b;
            phase = PH_OPT;
          end else begin
            phase = PH_NORMAL;
          end
        end
        PH_OPT: begin
          if (verb == T_DO && b == T_NAWS) add_window_reply();
          phase = PH_NORMAL;
        end
        PH_SUB: begin
          if (b == T_IAC) phase = PH_SUBIAC;
        end
        PH_SUBIAC: begin
          phase = (b == T_SE) ? PH_NORMAL : PH_SUB;
        end
        default: begin
          if (b == T_IAC) begin
            phase = PH_IAC;
          end else begin
            add_due(1'b0, b, 1'b1);
            phase = PH_NORMAL;
          end
        end
      endcase
    endfunction

    function void check_emitted(logic dir, logic [7:0] value, logic last);
      emitted_t e;
      if (due_bytes.size() == 0) begin
        $error("unexpected output transfer: to_server %0d out_byte 0x%02h last_of_run %0d",
               dir, value, last);
        errors++;
        return;
      end
      e = due_bytes.pop_front();
      if (dir !== e.to_server) begin
        $error("to_server mismatch: expected %0d, actual %0d", e.to_server, dir);
        errors++;
      end
      if (value !== e.value) begin
        $error("out_byte mismatch: expected 0x%02h, actual 0x%02h", e.value, value);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_of_run mismatch: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  server_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        to_server;
  logic [7:0]  out_byte;
  logic        last_of_run;

  stripped_stream_board sb = new();
  bit bursts_on = 1'b1;
  int stall_left = 0;
  int cycles = 0;

  telnet_iac_stripper_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .server_byte (server_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .to_server   (to_server),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** telnet_iac_stripper_core: FAILED **");
      $finish;
    end
  end

  // output side: check each transfer, stall in random bursts
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_emitted(to_server, out_byte, last_of_run);
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    server_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_server_byte(b);
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [15:0] cols, input logic [15:0] rws);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_COLUMNS;
    cfg_data  <= cols;
    @(posedge clk);
    sb.set_window(REG_COLUMNS, cols);
    cfg_index <= REG_ROWS;
    cfg_data  <= rws;
    @(posedge clk);
    sb.set_window(REG_ROWS, rws);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random(input int count);
    logic [7:0] chunk[$];
    logic [7:0] b;
    int sent;
    sent = 0;
    while (sent < count) begin
      chunk = {};
      case ($urandom_range(0, 9))
        0, 1, 2: chunk.push_back(8'($urandom_range(0, 254)));
        3: chunk = {T_IAC, T_IAC};
        4: chunk = {T_IAC, 8'($urandom_range(0, 8'hF9))};
        5: begin
          b = ($urandom_range(0, 3) == 0) ? T_NAWS : 8'($urandom_range(0, 255));
          chunk = {T_IAC, 8'(T_WILL + $urandom_range(0, 3)), b};
        end
        6: chunk = {T_IAC, T_DO, T_NAWS};
        7: begin
          chunk = {T_IAC, T_SB};
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 4) == 0) begin
              b = 8'($urandom_range(0, 255));
              if (b == T_SE) b = T_IAC;
              chunk.push_back(T_IAC);
              chunk.push_back(b);
            end else begin
              chunk.push_back(8'($urandom_range(0, 254)));
            end
          end
          chunk.push_back(T_IAC);
          chunk.push_back(T_SE);
        end
        8: chunk.push_back(8'($urandom_range(0, 255)));
        default: chunk = {T_IAC, 8'(T_WILL + $urandom_range(0, 3))};
      endcase
      send_bytes(chunk);
      sent += chunk.size();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // plain bytes, escaped iac, commands, negotiation, subnegotiation
    send_bytes('{8'h00, 8'hFE, T_IAC, T_IAC, T_IAC, 8'hF1,
                 T_IAC, T_WILL, T_NAWS, T_IAC, T_WONT, T_NAWS, T_IAC, T_DONT, T_NAWS,
                 T_IAC, T_DO, T_NAWS, T_IAC, T_DO, 8'h00,
                 T_IAC, T_SB, T_IAC, T_IAC, 8'h18, T_IAC, T_SE});

    write_window(16'h0000, 16'h0000);
    send_bytes('{T_IAC, T_DO, T_NAWS});
    send_random(47);

    write_window(16'hFFFF, 16'hFFFF);
    send_bytes('{T_IAC, T_DO, T_NAWS});
    send_random(47);

    write_window(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    send_random(48);

    write_window(16'h00FF, 16'hFF00);
    send_random(48);

    write_window(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    bursts_on = 1'b0;
    send_random(46);

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** telnet_iac_stripper_core: PASSED **");
    end else begin
      $display("** telnet_iac_stripper_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/tis_pkg.sv
src/tis_parser.sv
src/telnet_iac_stripper_core.sv
sim/telnet_iac_stripper_core_tb.sv
